FILE: rtl/core/gnsm_pkg.sv
// Shared widths, queue entry type and command codes for the nearest-segment matcher.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package gnsm_pkg;

    localparam int DELTA_BITS = 24;
    localparam int LAT_W      = 31;
    localparam int LON_W      = 32;
    localparam int CFG_W      = 24;
    localparam int DLT_W      = DELTA_BITS + 1;          // endpoint difference B-A
    localparam int PRD_W      = 2 * DLT_W;               // small signed product
    localparam int OFF_W      = 2 * DELTA_BITS + 1;      // cross and along terms
    localparam int NORM_W     = 2 * DELTA_BITS + 2;      // squared segment length
    localparam int SQ_W       = 2 * OFF_W;               // squared cross magnitude
    localparam int WT_W       = SQ_W + NORM_W;           // distance weight
    localparam int SCL_W      = OFF_W + DLT_W;           // foot offset numerator
    localparam int MCNT_W     = $clog2(NORM_W);
    localparam int DCNT_W     = $clog2(SCL_W);
    localparam int MUL_STEPS  = 6;
    localparam int VHW_RESET  = 21213;
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 64;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_SEG   = 2'd1,
        OP_SKIP  = 2'd2
    } op_t;

    typedef struct packed {
        op_t                            op;
        logic                           last;
        logic signed [DELTA_BITS-1:0]   ay;
        logic signed [DELTA_BITS-1:0]   ax;
        logic signed [DELTA_BITS-1:0]   by;
        logic signed [DELTA_BITS-1:0]   bx;
        logic        [LAT_W-1:0]        ref_lat;
        logic        [LON_W-1:0]        ref_lon;
    } entry_t;

endpackage

FILE: rtl/core/gps_nearest_segment_match_unit.sv
// Top level of the nearest-segment map matcher: front end, entry queue and back end.
// Depends on gnsm_pkg, gnsm_front, gnsm_fifo, gnsm_back (with gnsm_smul).
//
//  channel | direction | tdata (low bit up)                   | tuser   | tlast
//  s_      | in        | lat_a, lon_a, lat_b, lon_b, 2'b0     | cmd     | last
//  m_      | out       | match_lat, match_lon, 1'b0           | matched | -
//  cfg_    | in        | cfg_wdata = view_half_width          | -       | -
//
// The front end takes a beat whenever the two-entry queue has room. Start and skipped beats
// pass through the back end without multiplies; a segment runs its signed products and, when it
// must be compared with a held best, four passes of the one-bit-per-cycle serial multiplier.
// A result adds two foot terms (each a multiply, a restoring division and a rounding step)
// and an output state. aresetn is synchronous, active low; stalls on m_ hold the back end
// only, the queue keeps s_ taking beats until both of its entries are full.
module gps_nearest_segment_match_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [gnsm_pkg::CFG_W-1:0]      cfg_wdata,   // view_half_width
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [gnsm_pkg::IN_DATA_W-1:0]  s_tdata,     // lat_a, lon_a, lat_b, lon_b
    input  logic                            s_tuser,     // cmd
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [gnsm_pkg::OUT_DATA_W-1:0] m_tdata,     // match_lat, match_lon
    output logic                            m_tuser      // matched
);

    logic             q_full, q_push, q_valid, q_pop;
    gnsm_pkg::entry_t q_push_ent, q_ent;

    gnsm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .q_full    (q_full),
        .push      (q_push),
        .push_ent  (q_push_ent)
    );

    gnsm_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_ent (q_push_ent),
        .full     (q_full),
        .rd_valid (q_valid),
        .rd_ent   (q_ent),
        .pop      (q_pop)
    );

    gnsm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ent    (q_ent),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: rtl/core/gnsm_front.sv
// Front end: takes input beats, holds the raw point and the box register, classifies segments.
// Depends on gnsm_pkg; feeds gnsm_fifo.
module gnsm_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [gnsm_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gnsm_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    input  logic                          s_tlast,
    input  logic                          q_full,
    output logic                          push,
    output gnsm_pkg::entry_t              push_ent
);

    localparam int LAT_W = gnsm_pkg::LAT_W;
    localparam int LON_W = gnsm_pkg::LON_W;
    localparam int DB    = gnsm_pkg::DELTA_BITS;

    logic [gnsm_pkg::CFG_W-1:0] vhw_reg;
    logic [LAT_W-1:0]           ref_lat_reg;
    logic [LON_W-1:0]           ref_lon_reg;

    logic [LAT_W-1:0] lat_a, lat_b;
    logic [LON_W-1:0] lon_a, lon_b;
    logic signed [LAT_W:0] ay, by, hy;
    logic signed [LON_W:0] ax, bx, hx;
    logic outside, fits, is_start;

    assign lat_a = s_tdata[LAT_W-1:0];
    assign lon_a = s_tdata[LAT_W+LON_W-1:LAT_W];
    assign lat_b = s_tdata[2*LAT_W+LON_W-1:LAT_W+LON_W];
    assign lon_b = s_tdata[2*LAT_W+2*LON_W-1:2*LAT_W+LON_W];

    assign is_start = !s_tuser;
    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    always_comb begin
        ay = $signed({lat_a[LAT_W-1], lat_a}) - $signed({ref_lat_reg[LAT_W-1], ref_lat_reg});
        by = $signed({lat_b[LAT_W-1], lat_b}) - $signed({ref_lat_reg[LAT_W-1], ref_lat_reg});
        ax = $signed({lon_a[LON_W-1], lon_a}) - $signed({ref_lon_reg[LON_W-1], ref_lon_reg});
        bx = $signed({lon_b[LON_W-1], lon_b}) - $signed({ref_lon_reg[LON_W-1], ref_lon_reg});
        hy = $signed({{(LAT_W+1-gnsm_pkg::CFG_W){1'b0}}, vhw_reg});
        hx = $signed({{(LON_W+1-gnsm_pkg::CFG_W){1'b0}}, vhw_reg});
        outside = (ay > hy && by > hy) || (ay < -hy && by < -hy) ||
                  (ax > hx && bx > hx) || (ax < -hx && bx < -hx);
        // a delta fits when its upper bits are all copies of the sign
        fits = ((ay[LAT_W:DB-1] == '0) || (ay[LAT_W:DB-1] == '1)) &&
               ((by[LAT_W:DB-1] == '0) || (by[LAT_W:DB-1] == '1)) &&
               ((ax[LON_W:DB-1] == '0) || (ax[LON_W:DB-1] == '1)) &&
               ((bx[LON_W:DB-1] == '0) || (bx[LON_W:DB-1] == '1));

        push_ent.last = s_tlast;
        push_ent.ay   = ay[DB-1:0];
        push_ent.ax   = ax[DB-1:0];
        push_ent.by   = by[DB-1:0];
        push_ent.bx   = bx[DB-1:0];
        if (is_start) begin
            push_ent.op      = gnsm_pkg::OP_START;
            push_ent.ref_lat = lat_a;
            push_ent.ref_lon = lon_a;
        end else begin
            push_ent.op      = (!outside && fits) ? gnsm_pkg::OP_SEG : gnsm_pkg::OP_SKIP;
            push_ent.ref_lat = ref_lat_reg;
            push_ent.ref_lon = ref_lon_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vhw_reg     <= gnsm_pkg::CFG_W'(gnsm_pkg::VHW_RESET);
            ref_lat_reg <= '0;
            ref_lon_reg <= '0;
        end else begin
            if (cfg_we) begin
                vhw_reg <= cfg_wdata;
            end
            if (push && is_start) begin
                ref_lat_reg <= lat_a;
                ref_lon_reg <= lon_a;
            end
        end
    end

endmodule

FILE: rtl/core/gnsm_fifo.sv
// Two-entry queue between the front end and the back end.
// Depends on gnsm_pkg for the entry type.
module gnsm_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  gnsm_pkg::entry_t push_ent,
    output logic             full,
    output logic             rd_valid,
    output gnsm_pkg::entry_t rd_ent,
    input  logic             pop
);

    gnsm_pkg::entry_t ent_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_ent   = ent_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= push_ent;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

FILE: rtl/core/gnsm_smul.sv
// Shift-add serial multiplier, one multiplier bit per cycle, for the wide distance weights and foot terms.
// Depends on gnsm_pkg; used by gnsm_back.
module gnsm_smul (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [gnsm_pkg::SQ_W-1:0]     a,
    input  logic [gnsm_pkg::NORM_W-1:0]   b,
    output logic                          done,
    output logic [gnsm_pkg::WT_W-1:0]     p
);

    localparam int WT_W = gnsm_pkg::WT_W;

    logic [WT_W-1:0]               a_reg, acc_reg;
    logic [gnsm_pkg::NORM_W-1:0]   b_reg;
    logic [gnsm_pkg::MCNT_W-1:0]   cnt_reg;
    logic                          busy_reg, done_reg;

    assign done = done_reg;
    assign p    = acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                a_reg    <= {{(WT_W-gnsm_pkg::SQ_W){1'b0}}, a};
                b_reg    <= b;
                acc_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (b_reg[0]) begin
                    acc_reg <= acc_reg + a_reg;
                end
                a_reg   <= {a_reg[WT_W-2:0], 1'b0};
                b_reg   <= {1'b0, b_reg[gnsm_pkg::NORM_W-1:1]};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == gnsm_pkg::MCNT_W'(gnsm_pkg::NORM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/core/gnsm_back.sv
// Back end: measures each segment in view, keeps the nearest one, and builds the foot point result.
// Depends on gnsm_pkg and gnsm_smul; drains gnsm_fifo and drives the result channel.
module gnsm_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    input  gnsm_pkg::entry_t               q_ent,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [gnsm_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tuser
);

    localparam int DB     = gnsm_pkg::DELTA_BITS;
    localparam int DLT_W  = gnsm_pkg::DLT_W;
    localparam int PRD_W  = gnsm_pkg::PRD_W;
    localparam int OFF_W  = gnsm_pkg::OFF_W;
    localparam int NORM_W = gnsm_pkg::NORM_W;
    localparam int SQ_W   = gnsm_pkg::SQ_W;
    localparam int WT_W   = gnsm_pkg::WT_W;
    localparam int SCL_W  = gnsm_pkg::SCL_W;
    localparam int LAT_W  = gnsm_pkg::LAT_W;
    localparam int LON_W  = gnsm_pkg::LON_W;
    localparam int MUL_STEPS_C = gnsm_pkg::MUL_STEPS;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_CHECK, S_WGO, S_WWAIT, S_UPD, S_NEXT,
        S_EGO, S_EWAIT, S_DIV, S_ERND, S_OUT
    } state_t;

    state_t state_reg;

    logic signed [DB-1:0]     ax_reg, ay_reg;
    logic signed [DLT_W-1:0]  dx_reg, dy_reg;
    logic                     last_reg;
    logic [LAT_W-1:0]         ref_lat_reg, res_lat_reg;
    logic [LON_W-1:0]         ref_lon_reg, res_lon_reg;
    logic [2:0]               step_reg;
    logic signed [PRD_W-1:0]  prod_reg;
    logic [NORM_W-1:0]        norm_reg, best_norm_reg;
    logic signed [OFF_W-1:0]  along_reg, cross_reg, best_off_reg;
    logic signed [DLT_W-1:0]  best_dx_reg, best_dy_reg;
    logic                     found_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic [WT_W-1:0]          wn_reg;
    logic [1:0]               ph_reg;
    logic [SCL_W-1:0]         dvd_reg;
    logic [NORM_W-1:0]        rem_reg;
    logic [gnsm_pkg::DCNT_W-1:0] dcnt_reg;
    logic                     neg_reg;
    logic                     m_tvalid_reg, m_tuser_reg;
    logic [gnsm_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    logic signed [DLT_W-1:0]  mop_a, mop_b;
    logic signed [PRD_W-1:0]  mprod;
    logic [OFF_W-1:0]         mag_cross, mag_boff;
    logic [DLT_W-1:0]         mag_bdx, mag_bdy;
    logic                     mul_start, mul_done;
    logic [SQ_W-1:0]          mul_a;
    logic [NORM_W-1:0]        mul_b;
    logic [WT_W-1:0]          mul_p;
    logic [NORM_W:0]          r2;
    logic                     ge;
    logic [SCL_W-1:0]         q_rnd, q_sgn;
    logic                     qual;

    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        case (step_reg)
            3'd0:    begin mop_a = dx_reg;               mop_b = dx_reg; end
            3'd1:    begin mop_a = dy_reg;               mop_b = dy_reg; end
            3'd2:    begin mop_a = DLT_W'(ax_reg);       mop_b = dx_reg; end
            3'd3:    begin mop_a = DLT_W'(ay_reg);       mop_b = dy_reg; end
            3'd4:    begin mop_a = dx_reg;               mop_b = DLT_W'(ay_reg); end
            default: begin mop_a = dy_reg;               mop_b = DLT_W'(ax_reg); end
        endcase
        mprod = mop_a * mop_b;

        mag_cross = cross_reg[OFF_W-1] ? OFF_W'(-cross_reg) : OFF_W'(cross_reg);
        mag_boff  = best_off_reg[OFF_W-1] ? OFF_W'(-best_off_reg) : OFF_W'(best_off_reg);
        mag_bdx   = best_dx_reg[DLT_W-1] ? DLT_W'(-best_dx_reg) : DLT_W'(best_dx_reg);
        mag_bdy   = best_dy_reg[DLT_W-1] ? DLT_W'(-best_dy_reg) : DLT_W'(best_dy_reg);

        mul_start = (state_reg == S_WGO) || (state_reg == S_EGO);
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_EGO) begin
            mul_a = SQ_W'(mag_boff);
            mul_b = (ph_reg == 2'd0) ? NORM_W'(mag_bdy) : NORM_W'(mag_bdx);
        end else begin
            case (ph_reg)
                2'd0:    begin mul_a = SQ_W'(mag_cross); mul_b = NORM_W'(mag_cross); end
                2'd1:    begin mul_a = sq_reg;           mul_b = best_norm_reg; end
                2'd2:    begin mul_a = SQ_W'(mag_boff);  mul_b = NORM_W'(mag_boff); end
                default: begin mul_a = sq_reg;           mul_b = norm_reg; end
            endcase
        end

        r2 = {rem_reg, dvd_reg[SCL_W-1]};
        ge = (r2 >= {1'b0, best_norm_reg});

        // round half away from zero on the magnitude, then apply the sign
        q_rnd = dvd_reg + SCL_W'({rem_reg, 1'b0} >= {1'b0, best_norm_reg});
        q_sgn = neg_reg ? SCL_W'(-q_rnd) : q_rnd;

        qual = (norm_reg != '0) && !along_reg[OFF_W-1] &&
               ({{(NORM_W-OFF_W){1'b0}}, along_reg} <= norm_reg);
    end

    gnsm_smul u_smul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .p       (mul_p)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            step_reg     <= '0;
            ph_reg       <= '0;
            dcnt_reg     <= '0;
        end else begin
            if (m_tready && (state_reg != S_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        ax_reg      <= q_ent.ax;
                        ay_reg      <= q_ent.ay;
                        dx_reg      <= {q_ent.bx[DB-1], q_ent.bx} - {q_ent.ax[DB-1], q_ent.ax};
                        dy_reg      <= {q_ent.by[DB-1], q_ent.by} - {q_ent.ay[DB-1], q_ent.ay};
                        last_reg    <= q_ent.last;
                        ref_lat_reg <= q_ent.ref_lat;
                        ref_lon_reg <= q_ent.ref_lon;
                        step_reg    <= '0;
                        case (q_ent.op)
                            gnsm_pkg::OP_START: begin
                                found_reg <= 1'b0;
                                state_reg <= S_NEXT;
                            end
                            gnsm_pkg::OP_SEG: state_reg <= S_MUL;
                            default:          state_reg <= S_NEXT;
                        endcase
                    end
                end
                S_MUL: begin
                    prod_reg <= mprod;
                    case (step_reg)
                        3'd1: norm_reg  <= NORM_W'(prod_reg);
                        3'd2: norm_reg  <= norm_reg + NORM_W'(prod_reg);
                        3'd3: along_reg <= -OFF_W'(prod_reg);
                        3'd4: along_reg <= along_reg - OFF_W'(prod_reg);
                        3'd5: cross_reg <= OFF_W'(prod_reg);
                        3'd6: cross_reg <= cross_reg - OFF_W'(prod_reg);
                        default: ;
                    endcase
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 3'(MUL_STEPS_C)) begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    ph_reg <= '0;
                    if (!qual) begin
                        state_reg <= S_NEXT;
                    end else if (!found_reg) begin
                        state_reg <= S_UPD;
                    end else begin
                        state_reg <= S_WGO;
                    end
                end
                S_WGO: state_reg <= S_WWAIT;
                S_WWAIT: begin
                    if (mul_done) begin
                        ph_reg <= ph_reg + 1'b1;
                        case (ph_reg)
                            2'd0: begin sq_reg <= mul_p[SQ_W-1:0]; state_reg <= S_WGO; end
                            2'd1: begin wn_reg <= mul_p;           state_reg <= S_WGO; end
                            2'd2: begin sq_reg <= mul_p[SQ_W-1:0]; state_reg <= S_WGO; end
                            default: state_reg <= (wn_reg < mul_p) ? S_UPD : S_NEXT;
                        endcase
                    end
                end
                S_UPD: begin
                    best_dx_reg   <= dx_reg;
                    best_dy_reg   <= dy_reg;
                    best_off_reg  <= cross_reg;
                    best_norm_reg <= norm_reg;
                    found_reg     <= 1'b1;
                    state_reg     <= S_NEXT;
                end
                S_NEXT: begin
                    ph_reg      <= '0;
                    res_lat_reg <= ref_lat_reg;
                    res_lon_reg <= ref_lon_reg;
                    if (!last_reg) begin
                        state_reg <= S_IDLE;
                    end else if (found_reg) begin
                        state_reg <= S_EGO;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                S_EGO: begin
                    // lon moves by offset * -dy, lat by offset * dx
                    if (ph_reg == 2'd0) begin
                        neg_reg <= best_off_reg[OFF_W-1] ^
                                   (!best_dy_reg[DLT_W-1] && (best_dy_reg != '0));
                    end else begin
                        neg_reg <= best_off_reg[OFF_W-1] ^ best_dx_reg[DLT_W-1];
                    end
                    state_reg <= S_EWAIT;
                end
                S_EWAIT: begin
                    if (mul_done) begin
                        dvd_reg   <= mul_p[SCL_W-1:0];
                        rem_reg   <= '0;
                        dcnt_reg  <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    rem_reg  <= ge ? NORM_W'(r2 - {1'b0, best_norm_reg}) : NORM_W'(r2);
                    dvd_reg  <= {dvd_reg[SCL_W-2:0], ge};
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == gnsm_pkg::DCNT_W'(SCL_W - 1)) begin
                        state_reg <= S_ERND;
                    end
                end
                S_ERND: begin
                    if (ph_reg == 2'd0) begin
                        res_lon_reg <= res_lon_reg + q_sgn[LON_W-1:0];
                        ph_reg      <= 2'd1;
                        state_reg   <= S_EGO;
                    end else begin
                        res_lat_reg <= res_lat_reg + q_sgn[LAT_W-1:0];
                        state_reg   <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= found_reg;
                        m_tdata_reg  <= {{(gnsm_pkg::OUT_DATA_W-LAT_W-LON_W){1'b0}},
                                         res_lon_reg, res_lat_reg};
                        found_reg    <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/core/gnsm_chk.sv
// Port-level checker for the nearest-segment matcher, bound to the top level.
// Depends on gnsm_pkg for port widths.
module gnsm_chk (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [gnsm_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                            m_tuser
);

    // reset empties the output register
    a_rst_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // reset empties the queue, so input is ready at once
    a_rst_in: assert property (@(posedge aclk) !aresetn |=> s_tready)
        else $error("input not ready after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // a result needs a beat through the queue and the back end
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(aresetn, 2))
        else $error("result too soon after reset");

endmodule

bind gps_nearest_segment_match_unit gnsm_chk u_chk (.*);
